FILE: hw/rtl/xyd_pkg.sv
// Package for the XY dimension-order express-link route unit.
// Holds item and configuration types, register indexes and reset values.
// No dependencies.
package xyd_pkg;

	// Mesh coordinates per dimension; a destination must lie below this bound
	localparam int MESH_SIZE = 16;
	// Default number of link indexes built per direction
	localparam int NUM_LINKS = 4;
	// Link indexes that the register map and the result mask provide
	localparam int LINK_MAX = 4;

	localparam int COORD_W = 4;
	localparam int LEN_W = 4;
	localparam int CNT_W = 3;
	localparam int PORT_W = 2;
	localparam int DIR_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_X,
		REG_OWN_Y,
		REG_LINK_LEN_0,
		REG_LINK_LEN_1,
		REG_LINK_LEN_2,
		REG_LINK_LEN_3,
		REG_LINKS_IN_USE
	} reg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_EAST,
		DIR_WEST,
		DIR_SOUTH,
		DIR_NORTH
	} dir_t;

	localparam logic [COORD_W-1:0] OWN_X_RST = '0;
	localparam logic [COORD_W-1:0] OWN_Y_RST = '0;
	localparam logic [LINK_MAX-1:0][LEN_W-1:0] LINK_LEN_RST = {4'd8, 4'd4, 4'd2, 4'd1};
	localparam logic [CNT_W-1:0] LINKS_IN_USE_RST = 3'd1;

	typedef struct packed {
		logic [COORD_W-1:0]                own_x;
		logic [COORD_W-1:0]                own_y;
		logic [LINK_MAX-1:0][LEN_W-1:0]    link_len;
		logic [CNT_W-1:0]                  links_in_use;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               start_dim;
		logic [PORT_W-1:0]  term_port;
	} req_t;

	typedef struct packed {
		logic                eject;
		logic [PORT_W-1:0]   eject_port;
		logic                route_dim;
		logic [DIR_W-1:0]    direction;
		logic [LINK_MAX-1:0] link_mask;
	} rsp_t;

endpackage

FILE: hw/rtl/xyd_if.sv
// Valid/ready channel interfaces for route requests and route results.
// Depends on xyd_pkg for field widths.
interface xyd_req_if import xyd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] dest_x;
	logic [COORD_W-1:0] dest_y;
	logic               start_dim;
	logic [PORT_W-1:0]  term_port;

	modport source (output valid, dest_x, dest_y, start_dim, term_port, input ready);
	modport sink (input valid, dest_x, dest_y, start_dim, term_port, output ready);
endinterface

interface xyd_rsp_if import xyd_pkg::*;;
	logic                valid;
	logic                ready;
	logic                eject;
	logic [PORT_W-1:0]   eject_port;
	logic                route_dim;
	logic [DIR_W-1:0]    direction;
	logic [LINK_MAX-1:0] link_mask;

	modport source (output valid, eject, eject_port, route_dim, direction, link_mask,
		input ready);
	modport sink (input valid, eject, eject_port, route_dim, direction, link_mask,
		output ready);
endinterface

FILE: hw/rtl/xy_dor_express_link_route.sv
// XY dimension-order route unit for a 2D mesh router with express links.
// A request is captured in the request register and its route decision in the result
// register, which offers it. Throughput: one item per cycle while results are taken; a
// stalled result still leaves room for one more item in the request register.
// Reset (arst_n low, asynchronous): both stages empty, registers to their
// documented defaults (own 0/0, spans 1/2/4/8, one link in use).
module xy_dor_express_link_route import xyd_pkg::*; #(
	parameter int NUM_LINKS = xyd_pkg::NUM_LINKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	xyd_req_if.sink               req,
	xyd_rsp_if.source             rsp
);

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_d;
	rsp_t rsp_s2;
	logic valid_s2;
	logic adv_s2;
	logic adv_s1;

	xyd_cfg #(
		.NUM_LINKS (NUM_LINKS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Result stage advances when empty or when its item is being taken;
	// request stage advances when empty or when the result stage can take its item.
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the request payload; hold it while the result stage is stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1.dest_x    <= req.dest_x;
			req_s1.dest_y    <= req.dest_y;
			req_s1.start_dim <= req.start_dim;
			req_s1.term_port <= req.term_port;
		end
	end

	xyd_route #(
		.NUM_LINKS (NUM_LINKS)
	) u_route (
		.req (req_s1),
		.cfg (cfg),
		.rsp (rsp_d)
	);

	// Register the decision; hold it until the sink takes it
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.eject      = rsp_s2.eject;
	assign rsp.eject_port = rsp_s2.eject_port;
	assign rsp.route_dim  = rsp_s2.route_dim;
	assign rsp.direction  = rsp_s2.direction;
	assign rsp.link_mask  = rsp_s2.link_mask;

endmodule

FILE: hw/rtl/xyd_cfg.sv
// Configuration register file of the route unit: coordinates, link spans, link count.
// Depends on xyd_pkg.
module xyd_cfg import xyd_pkg::*; #(
	parameter int NUM_LINKS = xyd_pkg::NUM_LINKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	localparam int LINK_CAP = (NUM_LINKS < LINK_MAX) ? NUM_LINKS : LINK_MAX;

	logic [COORD_W-1:0] own_x_q;
	logic [COORD_W-1:0] own_y_q;
	logic [CNT_W-1:0]   links_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q        <= OWN_X_RST;
			own_y_q        <= OWN_Y_RST;
			links_in_use_q <= LINKS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_OWN_X:        own_x_q        <= cfg_wdata[COORD_W-1:0];
				REG_OWN_Y:        own_y_q        <= cfg_wdata[COORD_W-1:0];
				REG_LINKS_IN_USE: links_in_use_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Only the link indexes that exist get a span register
	for (genvar j = 0; j < LINK_MAX; j++) begin : g_len
		if (j < LINK_CAP) begin : g_reg
			logic [LEN_W-1:0] len_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					len_q <= LINK_LEN_RST[j];
				end else if (cfg_we && cfg_idx == CFG_IDX_W'(int'(REG_LINK_LEN_0) + j)) begin
					len_q <= cfg_wdata[LEN_W-1:0];
				end
			end
			assign cfg.link_len[j] = len_q;
		end else begin : g_none
			assign cfg.link_len[j] = '0;
		end
	end

	assign cfg.own_x        = own_x_q;
	assign cfg.own_y        = own_y_q;
	assign cfg.links_in_use = links_in_use_q;

endmodule

FILE: hw/rtl/xyd_route.sv
// Route decision for one registered request: dimension skip, ejection, direction, link mask.
// Depends on xyd_pkg.
module xyd_route import xyd_pkg::*; #(
	parameter int NUM_LINKS = xyd_pkg::NUM_LINKS
) (
	input  req_t req,
	input  cfg_t cfg,
	output rsp_t rsp
);

	localparam int LINK_CAP = (NUM_LINKS < LINK_MAX) ? NUM_LINKS : LINK_MAX;

	logic                eject;
	logic                dim;
	logic [COORD_W-1:0]  sel_dest;
	logic [COORD_W-1:0]  sel_own;
	logic                neg;
	logic [COORD_W-1:0]  offs;
	logic [CNT_W-1:0]    n_eff;
	logic [LINK_MAX-1:0] present;
	logic [LINK_MAX-1:0] fit;
	logic [LEN_W-1:0]    best;
	logic                in_mesh;

	always_comb begin
		// Skip X when it already matches; Y is the last dimension
		dim      = req.start_dim | (req.dest_x == cfg.own_x);
		eject    = dim & (req.dest_y == cfg.own_y);
		sel_dest = dim ? req.dest_y : req.dest_x;
		sel_own  = dim ? cfg.own_y : cfg.own_x;
		neg      = sel_dest < sel_own;
		offs     = neg ? (sel_own - sel_dest) : (sel_dest - sel_own);
		in_mesh  = int'(sel_dest) < MESH_SIZE;

		// Saturate the link count to the links that exist; a count of zero acts as one
		n_eff = (cfg.links_in_use == '0) ? CNT_W'(1) : cfg.links_in_use;
		if (int'(n_eff) > LINK_CAP) begin
			n_eff = CNT_W'(LINK_CAP);
		end

		best = '0;
		for (int j = 0; j < LINK_MAX; j++) begin
			present[j] = j < int'(n_eff);
			fit[j]     = present[j] && (cfg.link_len[j] <= offs);
			if (fit[j] && cfg.link_len[j] > best) begin
				best = cfg.link_len[j];
			end
		end

		rsp.eject      = eject;
		rsp.eject_port = eject ? req.term_port : '0;
		rsp.route_dim  = eject ? 1'b0 : dim;
		rsp.direction  = eject ? DIR_EAST : {dim, neg};
		for (int j = 0; j < LINK_MAX; j++) begin
			rsp.link_mask[j] = !eject && in_mesh && (|fit) && present[j]
				&& (cfg.link_len[j] == best);
		end
	end

endmodule

FILE: tb/sv/xy_dor_express_link_route_chk.sv
`timescale 1ns / 100ps
// Checker for the XY express-link route unit: mirrors the register writes,
// predicts one route result per accepted request and compares it field by field.
// Depends on xyd_pkg and the channel interfaces in xyd_if.sv.
module xy_dor_express_link_route_chk import xyd_pkg::*; #(
	parameter int NUM_LINKS = xyd_pkg::NUM_LINKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	xyd_req_if                    req,
	xyd_rsp_if                    rsp,
	output int                    mismatch_cnt,
	output int                    routes_in_flight
);

	localparam int LINK_CAP = (NUM_LINKS < LINK_MAX) ? NUM_LINKS : LINK_MAX;

	cfg_t mirror;
	req_t ask;
	rsp_t want;
	rsp_t route_due_q[$];

	function automatic rsp_t predict_route(input req_t r, input cfg_t c);
		logic               dim;
		logic               fits;
		logic [COORD_W-1:0] tgt;
		logic [COORD_W-1:0] here;
		logic [COORD_W-1:0] span;
		logic [LEN_W-1:0]   best;
		int                 n_links;
		rsp_t               o;
		o = '0;
		// Skip X when it already matches; Y is never skipped past
		dim = r.start_dim;
		if (!dim && r.dest_x == c.own_x)
			dim = 1'b1;
		if (dim && r.dest_y == c.own_y) begin
			o.eject = 1'b1;
			o.eject_port = r.term_port;
			return o;
		end
		tgt = dim ? r.dest_y : r.dest_x;
		here = dim ? c.own_y : c.own_x;
		span = (tgt < here) ? here - tgt : tgt - here;
		o.route_dim = dim;
		if (dim)
			o.direction = (tgt < here) ? DIR_NORTH : DIR_SOUTH;
		else
			o.direction = (tgt < here) ? DIR_WEST : DIR_EAST;
		n_links = int'(c.links_in_use);
		if (n_links < 1)
			n_links = 1;
		if (n_links > LINK_CAP)
			n_links = LINK_CAP;
		fits = 1'b0;
		best = '0;
		if (int'(tgt) < MESH_SIZE) begin
			for (int j = 0; j < n_links; j++) begin
				if (c.link_len[j] <= span && (!fits || c.link_len[j] > best)) begin
					best = c.link_len[j];
					fits = 1'b1;
				end
			end
			if (fits)
				for (int j = 0; j < n_links; j++)
					if (c.link_len[j] == best)
						o.link_mask[j] = 1'b1;
		end
		return o;
	endfunction

	task automatic check_field(input string name, input logic [3:0] exp_v,
		input logic [3:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror.own_x = OWN_X_RST;
			mirror.own_y = OWN_Y_RST;
			mirror.link_len = LINK_LEN_RST;
			mirror.links_in_use = LINKS_IN_USE_RST;
			route_due_q.delete();
			routes_in_flight = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_OWN_X:        mirror.own_x = cfg_wdata;
					REG_OWN_Y:        mirror.own_y = cfg_wdata;
					REG_LINK_LEN_0:   mirror.link_len[0] = cfg_wdata;
					REG_LINK_LEN_1:   mirror.link_len[1] = cfg_wdata;
					REG_LINK_LEN_2:   mirror.link_len[2] = cfg_wdata;
					REG_LINK_LEN_3:   mirror.link_len[3] = cfg_wdata;
					REG_LINKS_IN_USE: mirror.links_in_use = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				ask.dest_x = req.dest_x;
				ask.dest_y = req.dest_y;
				ask.start_dim = req.start_dim;
				ask.term_port = req.term_port;
				route_due_q = {route_due_q, predict_route(ask, mirror)};
			end
			if (rsp.valid && rsp.ready) begin
				if (route_due_q.size() == 0) begin
					$display("%0t: unexpected route result, expected none, got mask %0d",
						$time, rsp.link_mask);
					mismatch_cnt++;
				end else begin
					want = route_due_q.pop_front();
					check_field("eject", 4'(want.eject), 4'(rsp.eject));
					check_field("eject_port", 4'(want.eject_port), 4'(rsp.eject_port));
					check_field("route_dim", 4'(want.route_dim), 4'(rsp.route_dim));
					check_field("direction", 4'(want.direction), 4'(rsp.direction));
					check_field("link_mask", want.link_mask, rsp.link_mask);
				end
			end
			routes_in_flight = route_due_q.size();
		end
	end

endmodule

FILE: tb/sv/xy_dor_express_link_route_tb.sv
`timescale 1ns / 100ps
// Top of the route unit testbench: clock, reset, register writes, request and
// result traffic, and the verdict. Depends on xyd_pkg, xyd_if.sv and the checker.
module xy_dor_express_link_route_tb import xyd_pkg::*;;

	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 4;
	// Watchdog limit, with plenty of headroom over the slowest honest run
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Register values last written, used to steer destinations near this node
	cfg_t        cur_cfg;
	// Calm: neither side idles; hold_off: ask the receiver for a long stall
	bit          calm;
	bit          hold_off;
	int unsigned cycle_cnt;
	int          mismatch_cnt;
	int          routes_in_flight;

	xyd_req_if req_ch();
	xyd_rsp_if rsp_ch();

	xy_dor_express_link_route i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	xy_dor_express_link_route_chk i_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.req              (req_ch),
		.rsp              (rsp_ch),
		.mismatch_cnt     (mismatch_cnt),
		.routes_in_flight (routes_in_flight)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic req_t mk_route(input int x, input int y, input int dim, input int port);
		req_t r;
		r.dest_x = COORD_W'(x);
		r.dest_y = COORD_W'(y);
		r.start_dim = dim[0];
		r.term_port = PORT_W'(port);
		return r;
	endfunction

	function automatic cfg_t mk_setting(input int x, input int y, input int l0, input int l1,
		input int l2, input int l3, input int n);
		cfg_t c;
		c.own_x = COORD_W'(x);
		c.own_y = COORD_W'(y);
		c.link_len[0] = LEN_W'(l0);
		c.link_len[1] = LEN_W'(l1);
		c.link_len[2] = LEN_W'(l2);
		c.link_len[3] = LEN_W'(l3);
		c.links_in_use = CNT_W'(n);
		return c;
	endfunction

	// Favour the mesh edges for the node's own position
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// Destination coordinate: often on this node's row or column, often a few hops
	// away so that short spans get exercised, otherwise anywhere
	function automatic logic [COORD_W-1:0] aim(input logic [COORD_W-1:0] here);
		int unsigned          roll;
		logic [COORD_W-1:0]   hop;
		roll = $urandom_range(99);
		hop = COORD_W'($urandom_range(1, 3));
		if (roll < 30)
			return here;
		if (roll < 55)
			return $urandom_range(1) ? here + hop : here - hop;
		return COORD_W'($urandom);
	endfunction

	function automatic req_t random_route();
		req_t r;
		r.dest_x = aim(cur_cfg.own_x);
		r.dest_y = aim(cur_cfg.own_y);
		r.start_dim = 1'($urandom_range(1));
		r.term_port = PORT_W'($urandom);
		return r;
	endfunction

	// Random spans, mostly ascending as intended, sometimes left unsorted;
	// the link count covers the out-of-range codes too
	function automatic cfg_t random_setting();
		cfg_t             c;
		logic [LEN_W-1:0] t;
		c.own_x = pick_coord();
		c.own_y = pick_coord();
		for (int j = 0; j < LINK_MAX; j++)
			c.link_len[j] = LEN_W'($urandom);
		if ($urandom_range(99) < 70) begin
			for (int a = 0; a < LINK_MAX - 1; a++)
				for (int b = 0; b < LINK_MAX - 1 - a; b++)
					if (c.link_len[b] > c.link_len[b+1]) begin
						t = c.link_len[b];
						c.link_len[b] = c.link_len[b+1];
						c.link_len[b+1] = t;
					end
		end
		c.links_in_use = CNT_W'($urandom_range(7));
		return c;
	endfunction

	// Write every register in index order, one per cycle; only call while idle
	task automatic load_config(input cfg_t c);
		logic [CFG_DATA_W-1:0] val;
		for (int i = 0; i <= REG_LINKS_IN_USE; i++) begin
			case (reg_idx_t'(i))
				REG_OWN_X:        val = c.own_x;
				REG_OWN_Y:        val = c.own_y;
				REG_LINK_LEN_0:   val = c.link_len[0];
				REG_LINK_LEN_1:   val = c.link_len[1];
				REG_LINK_LEN_2:   val = c.link_len[2];
				REG_LINK_LEN_3:   val = c.link_len[3];
				REG_LINKS_IN_USE: val = CFG_DATA_W'(c.links_in_use);
				default:          val = '0;
			endcase
			cfg_we <= 1'b1;
			cfg_idx <= reg_idx_t'(i);
			cfg_wdata <= val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	// Offer one item, idling first at random, and hold it until accepted
	task automatic send_route(input req_t r);
		while (!calm && $urandom_range(99) < 36) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.dest_x <= r.dest_x;
		req_ch.dest_y <= r.dest_y;
		req_ch.start_dim <= r.start_dim;
		req_ch.term_port <= r.term_port;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drop valid and wait until every predicted result has been seen
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (routes_in_flight != 0);
	endtask

	// Result side: random back-pressure, or a long counted stall on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= 36);
		end
	end

	initial begin
		cfg_t c;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_OWN_X;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.dest_x <= '0;
		req_ch.dest_y <= '0;
		req_ch.start_dim <= 1'b0;
		req_ch.term_port <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: node at the origin, one link of span 1
		send_route(mk_route(0, 0, 0, 1));
		send_route(mk_route(5, 0, 0, 2));
		send_route(mk_route(0, 9, 1, 3));
		settle();

		// Mid-mesh node with the usual 1/2/4/8 spans
		load_config(mk_setting(7, 8, 1, 2, 4, 8, 4));
		send_route(mk_route(7, 8, 0, 3));    // both match: eject
		send_route(mk_route(7, 8, 1, 2));
		send_route(mk_route(3, 8, 1, 1));    // start in Y, Y matches: eject despite X
		send_route(mk_route(15, 8, 0, 0));   // east, longest span exactly
		send_route(mk_route(0, 8, 0, 1));    // west, 7 hops rounds down to 4
		send_route(mk_route(7, 15, 0, 2));   // X matches, fall through to south
		send_route(mk_route(7, 0, 1, 3));    // north 8
		send_route(mk_route(8, 3, 0, 0));    // east one hop
		send_route(mk_route(6, 0, 1, 1));    // start in Y ignores the X mismatch
		send_route(mk_route(0, 15, 0, 1));
		send_route(mk_route(15, 15, 1, 3));
		settle();

		// Unsorted spans with a zero span, link count beyond the cap
		load_config(mk_setting(0, 0, 15, 3, 0, 3, 7));
		send_route(mk_route(15, 0, 0, 2));
		send_route(mk_route(2, 0, 0, 1));    // only the zero span fits
		send_route(mk_route(3, 9, 0, 0));    // two links share the best span
		send_route(mk_route(0, 0, 0, 3));
		send_route(mk_route(0, 15, 0, 0));
		send_route(mk_route(0, 1, 1, 2));
		settle();

		// Far corner, long spans only, link count zero acting as one
		load_config(mk_setting(15, 15, 15, 15, 15, 15, 0));
		send_route(mk_route(0, 15, 0, 1));
		send_route(mk_route(14, 15, 0, 2));  // nothing fits: empty mask
		send_route(mk_route(15, 0, 0, 3));
		send_route(mk_route(15, 14, 1, 0));
		settle();

		// Random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       c = mk_setting(15, 15, 15, 15, 15, 15, 4);
				1:       c = mk_setting(0, 0, 1, 1, 1, 1, 4);
				default: c = random_setting();
			endcase
			calm = (p == 4);
			load_config(c);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Stall the results while requests keep coming, so the unit backs up
				if (p == 3 && k == 40)
					hold_off = 1'b1;
				// Pause the sender until the unit has drained completely
				if (p == 5 && k == 75)
					settle();
				send_route(random_route());
			end
			settle();
		end
		calm = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && routes_in_flight == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/xyd_pkg.sv
hw/rtl/xyd_if.sv
hw/rtl/xyd_cfg.sv
hw/rtl/xyd_route.sv
hw/rtl/xy_dor_express_link_route.sv
tb/sv/xy_dor_express_link_route_chk.sv
tb/sv/xy_dor_express_link_route_tb.sv
